/* rtl/tps_pkg.sv */
// shared types, widths, register indexes and reset values for the trapezoidal shaper
package tps_pkg;

    localparam int HISTORY_DEPTH_DEF = 512;

    localparam int SAMPLE_W   = 17;
    localparam int RISE_W     = 8;
    localparam int FLAT_W     = 8;
    localparam int DECAY_W    = 16;
    localparam int GAIN_W     = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIFF_W     = SAMPLE_W + 2;
    localparam int MD_W       = DECAY_W + 1 + DIFF_W;
    localparam int P_W        = 48;
    localparam int S_W        = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CONSTANT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_GAIN      = 2'd3;

    localparam logic [RISE_W-1:0]  RISE_RESET  = 8'd20;
    localparam logic [FLAT_W-1:0]  FLAT_RESET  = 8'd30;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd12500;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd4398047;

    // which delayed sample a read or an accumulate step refers to
    typedef enum logic [1:0] {
        TAP_K,
        TAP_L,
        TAP_KL
    } tap_t;

    typedef struct packed {
        logic [RISE_W-1:0]  rise_length;
        logic [FLAT_W-1:0]  flat_length;
        logic [DECAY_W-1:0] decay_constant;
        logic [GAIN_W-1:0]  norm_gain;
    } tps_cfg_t;

    typedef struct packed {
        logic cap_in;
        logic rd_en;
        tap_t rd_tap;
        logic acc_en;
        tap_t acc_tap;
        logic pd_en;
        logic s_en;
        logic mul_en;
        logic out_load;
    } tps_cmd_t;

endpackage

/* rtl/tps_ctrl.sv */
// sequencer for the trapezoidal shaper: steps one sample through reads, accumulate and scale
module tps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tps_pkg::tps_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_RD_K   = 9'b000000010,
        ST_RD_L   = 9'b000000100,
        ST_RD_KL  = 9'b000001000,
        ST_ACC    = 9'b000010000,
        ST_MUL_PD = 9'b000100000,
        ST_SUM_S  = 9'b001000000,
        ST_MUL_G  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_tap   = tps_pkg::TAP_K;
        cmd.acc_tap  = tps_pkg::TAP_K;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_RD_K;
                end
            end
            ST_RD_K: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tap = tps_pkg::TAP_K;
                state_next = ST_RD_L;
            end
            ST_RD_L: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tap  = tps_pkg::TAP_L;
                cmd.acc_en  = 1'b1;
                cmd.acc_tap = tps_pkg::TAP_K;
                state_next  = ST_RD_KL;
            end
            ST_RD_KL: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tap  = tps_pkg::TAP_KL;
                cmd.acc_en  = 1'b1;
                cmd.acc_tap = tps_pkg::TAP_L;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en  = 1'b1;
                cmd.acc_tap = tps_pkg::TAP_KL;
                state_next  = ST_MUL_PD;
            end
            ST_MUL_PD: begin
                cmd.pd_en  = 1'b1;
                state_next = ST_SUM_S;
            end
            ST_SUM_S: begin
                cmd.s_en   = 1'b1;
                state_next = ST_MUL_G;
            end
            ST_MUL_G: begin
                cmd.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait here only while the previous result is still unread
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/tps_datapath.sv */
// datapath of the trapezoidal shaper: sample history, difference, accumulators and scaling
module tps_datapath #(
    parameter int HISTORY_DEPTH = tps_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tps_pkg::tps_cmd_t                   cmd,
    input  tps_pkg::tps_cfg_t                   cfg,
    input  logic signed [tps_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_trace_start,
    output logic signed [tps_pkg::OUT_W-1:0]    m_shaped_value
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = (FW > 10) ? FW : 10;
    localparam logic [CW-1:0] DEPTH_C  = CW'(HISTORY_DEPTH);
    localparam logic [CW:0]   DEPTH_C1 = (CW + 1)'(HISTORY_DEPTH);
    localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

    localparam int SW = tps_pkg::SAMPLE_W;
    localparam int DW = tps_pkg::DIFF_W;
    localparam int PW = tps_pkg::P_W;
    localparam int SSW = tps_pkg::S_W;
    localparam int MW = tps_pkg::MD_W;
    localparam int RW = 65;

    localparam logic signed [RW-1:0] RES_MAX = 65'sd2147483647;
    localparam logic signed [RW-1:0] RES_MIN = -65'sd2147483648;

    // history store, contents beyond the fill count read as zero
    logic signed [SW-1:0] hist_mem [HISTORY_DEPTH];
    logic signed [SW-1:0] rd_data_reg;

    logic signed [SW-1:0]  sample_reg;
    logic signed [DW-1:0]  d_reg, d_next;
    logic [PW-1:0]         p_reg, p_next;
    logic signed [MW-1:0]  md_reg, md_next;
    logic [SSW-1:0]        s_reg, s_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [FW-1:0]         fill_reg, fill_next;
    logic signed [RW-1:0]  hi_prod_reg, hi_prod_next;
    logic [63:0]           lo_prod_reg, lo_prod_next;
    logic [tps_pkg::OUT_W-1:0] out_reg, out_next;

    logic [CW-1:0]        k_len, l_len, kl_len;
    logic [CW-1:0]        rd_dly, acc_dly;
    logic [CW:0]          rd_addr_w;
    logic [AW-1:0]        rd_addr;
    logic signed [SW-1:0] tap_val;
    logic signed [RW-1:0] res;

    function automatic logic [CW-1:0] clamp_dly(input logic [CW-1:0] dly);
        return (dly > DEPTH_C) ? DEPTH_C : dly;
    endfunction

    function automatic logic [CW-1:0] tap_len(input tps_pkg::tap_t tap,
                                              input logic [CW-1:0] k,
                                              input logic [CW-1:0] l,
                                              input logic [CW-1:0] kl);
        logic [CW-1:0] len;
        unique case (tap)
            tps_pkg::TAP_K:  len = k;
            tps_pkg::TAP_L:  len = l;
            tps_pkg::TAP_KL: len = kl;
            default:         len = k;
        endcase
        return len;
    endfunction

    assign k_len  = CW'(cfg.rise_length);
    assign l_len  = CW'(cfg.rise_length) + CW'(cfg.flat_length);
    assign kl_len = k_len + l_len;

    // read address: write pointer minus delay, wrapped once
    assign rd_dly = clamp_dly(tap_len(cmd.rd_tap, k_len, l_len, kl_len));
    always_comb begin
        if (CW'(wp_reg) >= rd_dly) begin
            rd_addr_w = {1'b0, CW'(wp_reg) - rd_dly};
        end else begin
            rd_addr_w = {1'b0, CW'(wp_reg)} + DEPTH_C1 - {1'b0, rd_dly};
        end
    end
    assign rd_addr = rd_addr_w[AW-1:0];

    // delayed sample: zero delay is the current sample, unwritten slots are zero
    assign acc_dly = clamp_dly(tap_len(cmd.acc_tap, k_len, l_len, kl_len));
    always_comb begin
        if (acc_dly == '0) begin
            tap_val = sample_reg;
        end else if (acc_dly <= CW'(fill_reg)) begin
            tap_val = rd_data_reg;
        end else begin
            tap_val = '0;
        end
    end

    always_comb begin
        d_next = d_reg;
        if (cmd.cap_in) begin
            d_next = DW'(s_sample);
        end else if (cmd.acc_en) begin
            if (cmd.acc_tap == tps_pkg::TAP_KL) begin
                d_next = d_reg + DW'(tap_val);
            end else begin
                d_next = d_reg - DW'(tap_val);
            end
        end
    end

    assign md_next = $signed({1'b0, cfg.decay_constant}) * d_reg;

    always_comb begin
        p_next    = p_reg;
        s_next    = s_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cmd.cap_in && s_trace_start) begin
            p_next    = '0;
            s_next    = '0;
            wp_next   = '0;
            fill_next = '0;
        end else if (cmd.pd_en) begin
            p_next = p_reg + {{(PW - DW){d_reg[DW-1]}}, d_reg};
        end else if (cmd.s_en) begin
            s_next = s_reg + {{(SSW - PW){p_reg[PW-1]}}, p_reg}
                           + {{(SSW - MW){md_reg[MW-1]}}, md_reg};
            wp_next = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != FILL_MAX) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // signed high word and unsigned low word of s, each times the gain
    assign hi_prod_next = $signed(s_reg[SSW-1:32]) * $signed({1'b0, cfg.norm_gain});
    assign lo_prod_next = s_reg[31:0] * cfg.norm_gain;

    assign res = hi_prod_reg + $signed({33'b0, lo_prod_reg[63:32]});

    always_comb begin
        if (res > RES_MAX) begin
            out_next = 32'h7FFF_FFFF;
        end else if (res < RES_MIN) begin
            out_next = 32'h8000_0000;
        end else begin
            out_next = res[tps_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= '0;
            s_reg    <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            p_reg    <= p_next;
            s_reg    <= s_next;
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            sample_reg <= s_sample;
        end
        d_reg <= d_next;
        if (cmd.pd_en) begin
            md_reg <= md_next;
        end
        if (cmd.mul_en) begin
            hi_prod_reg <= hi_prod_next;
            lo_prod_reg <= lo_prod_next;
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.s_en) begin
            hist_mem[wp_reg] <= sample_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign m_shaped_value = $signed(out_reg);

endmodule

/* rtl/trapezoidal_pulse_shaper.sv */
// top level of the trapezoidal pulse shaper: configuration registers, sequencer and datapath
//
// usage
// - input channel s_*: one beat carries a signed 17 bit sample and a trace_start flag;
//   trace_start clears the sample history and both accumulators before that sample
// - output channel m_*: one beat per input beat, the trapezoid value in signed Q23.8,
//   saturated to 32 bits
// - configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 rise length,
//   1 flat length, 2 decay constant, 3 normalising gain); write only while idle
// - result path: three history reads, last accumulate, decay multiply, sum, gain multiply
//   and output load; one sample at a time, set by the single read port of the history
//   memory (three delayed reads per sample) and the multiply stages that follow
// - the history uses a fill count, so samples older than the last clear read as zero
//   and no clearing sweep of the memory is needed
// - reset: synchronous, active low; registers return to their defaults, history and
//   accumulators are empty, no result is pending
// - stall: a finished result waits in the output register; the next sample is taken
//   and worked on meanwhile and holds in its last step until the register is free
module trapezoidal_pulse_shaper #(
    parameter int HISTORY_DEPTH = tps_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tps_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                                  s_trace_start,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tps_pkg::OUT_W-1:0]      m_shaped_value,
    input  logic                                  cfg_wr_en,
    input  logic [tps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    tps_pkg::tps_cfg_t cfg_reg, cfg_next;
    tps_pkg::tps_cmd_t cmd;

    // register writes, each keeps the low bits of the write data
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                tps_pkg::CFG_RISE_LENGTH:    cfg_next.rise_length    = cfg_wdata[7:0];
                tps_pkg::CFG_FLAT_LENGTH:    cfg_next.flat_length    = cfg_wdata[7:0];
                tps_pkg::CFG_DECAY_CONSTANT: cfg_next.decay_constant = cfg_wdata[15:0];
                tps_pkg::CFG_NORM_GAIN:      cfg_next.norm_gain      = cfg_wdata[31:0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_length    <= tps_pkg::RISE_RESET;
            cfg_reg.flat_length    <= tps_pkg::FLAT_RESET;
            cfg_reg.decay_constant <= tps_pkg::DECAY_RESET;
            cfg_reg.norm_gain      <= tps_pkg::GAIN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: one sample at a time, output valid kept here
    tps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // history memory, difference, accumulators, gain multiply and saturation
    tps_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg_reg),
        .s_sample       (s_sample),
        .s_trace_start  (s_trace_start),
        .m_shaped_value (m_shaped_value)
    );

`ifndef NO_ASSERTIONS
    // the sequencer captures a sample exactly on an input beat
    a_cap_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_in == (s_valid && s_ready))
        else $error("sample capture does not match input beat");

    // only one sample in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready again straight after a beat");

    // a result never overwrites one still waiting on the output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register loaded while holding an unread result");

    // a loaded result is presented in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule
